FILE: rtl/audio_level_beat_detector_core_defines.svh
// Assertion macros used by the audio level beat detector core.
`ifndef AUDIO_LEVEL_BEAT_DETECTOR_CORE_DEFINES_SVH
`define AUDIO_LEVEL_BEAT_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ALBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("albd: same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted.
`define ALBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("albd: next-cycle check failed");

`endif

FILE: rtl/albd_pkg.sv
package albd_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int TIME_W        = 32;
    localparam int LEVEL_W       = 7;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 16;
    localparam int SMOOTH_W      = 8;
    localparam int GAP_W         = 16;
    localparam int WINDOW_LEN_DEF = 16;

    localparam int WEIGHT_W      = SMOOTH_W + 1;
    localparam int ACC_W         = SAMPLE_BITS + WEIGHT_W;
    localparam int QUO_W         = LEVEL_W;
    localparam int DIV_W         = SAMPLE_BITS;
    localparam int DVD_W         = DIV_W + QUO_W;
    localparam int CNT_W         = 4;

    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};
    localparam logic [LEVEL_W-1:0]     LEVEL_MAX  = 7'd100;
    localparam logic [SAMPLE_BITS-1:0] PEAK_DECAY_NUM = 12'd4055;
    localparam int                     PEAK_DECAY_SHIFT = 12;

    localparam logic [SAMPLE_BITS-1:0] NOISE_FLOOR_RST = 12'd200;
    localparam logic [SMOOTH_W-1:0]    SMOOTH_RST      = 8'd205;
    localparam logic [GAP_W-1:0]       MIN_GAP_RST     = 16'd100;
    localparam logic [LEVEL_W-1:0]     MIN_LEVEL_RST   = 7'd20;

    localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_FACTOR  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP_MS     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_BEAT_LEVEL = 8'd3;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_IIR   = 7'b0000010,
        S_SCALE = 7'b0000100,
        S_DIVL  = 7'b0001000,
        S_WIN   = 7'b0010000,
        S_DIVM  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

endpackage

FILE: rtl/albd_if.sv
interface albd_in_if;
    logic                                valid;
    logic                                ready;
    logic [albd_pkg::SAMPLE_BITS-1:0]    sample;
    logic [albd_pkg::TIME_W-1:0]         time_ms;

    modport source(output valid, sample, time_ms, input ready);
    modport sink(input valid, sample, time_ms, output ready);
endinterface

interface albd_out_if;
    logic                                valid;
    logic                                ready;
    logic [albd_pkg::LEVEL_W-1:0]        level;
    logic                                beat;
    logic [albd_pkg::SAMPLE_BITS-1:0]    smoothed_sample;
    logic [albd_pkg::SAMPLE_BITS-1:0]    peak;
    logic [albd_pkg::LEVEL_W-1:0]        window_mean;

    modport source(output valid, level, beat, smoothed_sample, peak, window_mean,
                   input ready);
    modport sink(input valid, level, beat, smoothed_sample, peak, window_mean,
                 output ready);
endinterface

interface albd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [albd_pkg::CFG_IDX_W-1:0]      index;
    logic [albd_pkg::CFG_DATA_W-1:0]     data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/albd_ram.sv
module albd_ram #(
    parameter int WIDTH = albd_pkg::LEVEL_W,
    parameter int DEPTH = albd_pkg::WINDOW_LEN_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/audio_level_beat_detector_core.sv
// Channel  Direction  Words carried
// i_in     in         sample, time_ms
// o_out    out        level, beat, smoothed_sample, peak, window_mean
// i_cfg    in         index, data (register writes, always ready)
//
// A word goes from acceptance to a loaded result register through a bit-serial
// multiply-accumulate for the smoothing filter, then two seven-step restoring
// divisions on one shared divider for level and mean.
// The input is ready again the cycle after that load.
// Reset is synchronous and clears the filter, peak, window valid bits and beat time.
// A new word is accepted while a finished result still waits in the output
// register; the last step holds until that register is free.
`include "audio_level_beat_detector_core_defines.svh"

module audio_level_beat_detector_core #(
    parameter int WINDOW_LEN = albd_pkg::WINDOW_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    albd_in_if.sink     i_in,
    albd_out_if.source  o_out,
    albd_cfg_if.sink    i_cfg
);

    localparam int SB    = albd_pkg::SAMPLE_BITS;
    localparam int LW    = albd_pkg::LEVEL_W;
    localparam int TW    = albd_pkg::TIME_W;
    localparam int PW    = $clog2(WINDOW_LEN);
    localparam int TOT_W = $clog2(WINDOW_LEN * 100 + 1);
    localparam int ACC_W = albd_pkg::ACC_W;
    localparam int DIV_W = albd_pkg::DIV_W;
    localparam int DVD_W = albd_pkg::DVD_W;
    localparam int QW    = albd_pkg::QUO_W;
    localparam int CW    = albd_pkg::CNT_W;
    localparam int PEAK_SH = albd_pkg::PEAK_DECAY_SHIFT;
    localparam logic [TOT_W-1:0] TOT_MAX = TOT_W'(WINDOW_LEN * 100);

    albd_pkg::t_state r_state, n_state;

    logic [SB-1:0]                  r_noise_floor;
    logic [albd_pkg::SMOOTH_W-1:0]  r_smooth;
    logic [albd_pkg::GAP_W-1:0]     r_min_gap;
    logic [LW-1:0]                  r_min_level;

    logic [SB-1:0]                  r_filt, n_filt;
    logic [SB-1:0]                  r_peak, n_peak;
    logic [PW-1:0]                  r_pos, n_pos;
    logic [TOT_W-1:0]               r_total, n_total;
    logic [TW-1:0]                  r_last, n_last;
    logic [WINDOW_LEN-1:0]          r_win_vld, n_win_vld;
    logic                           r_out_valid, n_out_valid;

    logic [SB-1:0]                  r_sample;
    logic [TW-1:0]                  r_time;
    logic [ACC_W-1:0]               r_acc, n_acc;
    logic [DIV_W-1:0]               r_rem, n_rem;
    logic [QW-1:0]                  r_dvd_lo, n_dvd_lo;
    logic [DIV_W-1:0]               r_dvs, n_dvs;
    logic [QW-1:0]                  r_quo, n_quo;
    logic [CW-1:0]                  r_cnt, n_cnt;
    logic [LW-1:0]                  r_level, n_level;

    logic [LW-1:0]                  r_o_level, n_o_level;
    logic                           r_o_beat, n_o_beat;
    logic [SB-1:0]                  r_o_smooth, n_o_smooth;
    logic [SB-1:0]                  r_o_peak, n_o_peak;
    logic [LW-1:0]                  r_o_mean, n_o_mean;

    logic                           in_fire;
    logic                           out_free;
    logic [albd_pkg::WEIGHT_W-1:0]  w_prev;
    logic [albd_pkg::WEIGHT_W-1:0]  w_new;
    logic [SB:0]                    acc_hi;
    logic [SB-1:0]                  filt_now;
    logic                           lvl_ok;
    logic [SB-1:0]                  rem_val;
    logic [SB-1:0]                  span_val;
    logic [DVD_W-1:0]               lvl_dvd;
    logic [SB+PEAK_SH-1:0]          peak_prod;
    logic [DIV_W:0]                 div_try;
    logic                           div_ge;
    logic [LW-1:0]                  level_now;
    logic [LW-1:0]                  old_level;
    logic [TOT_W-1:0]               total_now;
    logic [DVD_W-1:0]               mean_dvd;
    logic [LW:0]                    thr;
    logic                           beat_now;
    logic                           ram_we;
    logic [LW-1:0]                  ram_rd_data;

    assign in_fire    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == albd_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid           = r_out_valid;
    assign o_out.level           = r_o_level;
    assign o_out.beat            = r_o_beat;
    assign o_out.smoothed_sample = r_o_smooth;
    assign o_out.peak            = r_o_peak;
    assign o_out.window_mean     = r_o_mean;

    albd_ram #(
        .WIDTH (LW),
        .DEPTH (WINDOW_LEN)
    ) u_window (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_pos),
        .i_wr_data (level_now),
        .i_rd_en   (in_fire),
        .i_rd_addr (r_pos),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        w_prev    = {1'b0, r_smooth};
        w_new     = 9'd256 - {1'b0, r_smooth};
        acc_hi    = r_acc[ACC_W-1:ACC_W-SB-1];
        filt_now  = acc_hi[SB] ? albd_pkg::FULL_SCALE : acc_hi[SB-1:0];
        lvl_ok    = (r_noise_floor < albd_pkg::FULL_SCALE) && (filt_now > r_noise_floor);
        rem_val   = filt_now - r_noise_floor;
        span_val  = albd_pkg::FULL_SCALE - r_noise_floor;
        lvl_dvd   = DVD_W'(rem_val) * DVD_W'(albd_pkg::LEVEL_MAX);
        peak_prod = (SB + PEAK_SH)'(r_peak) * (SB + PEAK_SH)'(albd_pkg::PEAK_DECAY_NUM);
        div_try   = {r_rem, r_dvd_lo[QW-1]};
        div_ge    = div_try >= {1'b0, r_dvs};
        level_now = (r_quo > albd_pkg::LEVEL_MAX) ? albd_pkg::LEVEL_MAX : r_quo;
        old_level = r_win_vld[r_pos] ? ram_rd_data : '0;
        total_now = r_total - TOT_W'(old_level) + TOT_W'(level_now);
        mean_dvd  = DVD_W'(total_now);
        thr       = {1'b0, r_quo} + {2'b00, r_quo[QW-1:1]};
        beat_now  = ({1'b0, r_level} > thr) && (r_level > r_min_level)
                    && ((r_time - r_last) > TW'(r_min_gap));
    end

    always_comb begin
        n_state     = r_state;
        n_filt      = r_filt;
        n_peak      = r_peak;
        n_pos       = r_pos;
        n_total     = r_total;
        n_last      = r_last;
        n_win_vld   = r_win_vld;
        n_out_valid = r_out_valid;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_dvd_lo    = r_dvd_lo;
        n_dvs       = r_dvs;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_level     = r_level;
        n_o_level   = r_o_level;
        n_o_beat    = r_o_beat;
        n_o_smooth  = r_o_smooth;
        n_o_peak    = r_o_peak;
        n_o_mean    = r_o_mean;
        ram_we      = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            albd_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_acc   = '0;
                    n_cnt   = CW'(albd_pkg::WEIGHT_W - 1);
                    n_state = albd_pkg::S_IIR;
                end
            end
            albd_pkg::S_IIR: begin
                n_acc = {r_acc[ACC_W-2:0], 1'b0}
                        + (w_prev[r_cnt] ? ACC_W'(r_filt) : '0)
                        + (w_new[r_cnt] ? ACC_W'(r_sample) : '0);
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = albd_pkg::S_SCALE;
                end
            end
            albd_pkg::S_SCALE: begin
                n_filt = filt_now;
                if (filt_now > r_peak) begin
                    n_peak = filt_now;
                end else begin
                    n_peak = peak_prod[SB+PEAK_SH-1:PEAK_SH];
                end
                if (lvl_ok) begin
                    n_rem    = lvl_dvd[DVD_W-1:QW];
                    n_dvd_lo = lvl_dvd[QW-1:0];
                    n_dvs    = span_val;
                end else begin
                    n_rem    = '0;
                    n_dvd_lo = '0;
                    n_dvs    = DIV_W'(1);
                end
                n_quo   = '0;
                n_cnt   = CW'(QW - 1);
                n_state = albd_pkg::S_DIVL;
            end
            albd_pkg::S_DIVL, albd_pkg::S_DIVM: begin
                n_rem    = div_ge ? DIV_W'(div_try - {1'b0, r_dvs}) : div_try[DIV_W-1:0];
                n_dvd_lo = {r_dvd_lo[QW-2:0], 1'b0};
                n_quo    = {r_quo[QW-2:0], div_ge};
                n_cnt    = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = (r_state == albd_pkg::S_DIVL) ? albd_pkg::S_WIN
                                                             : albd_pkg::S_DONE;
                end
            end
            albd_pkg::S_WIN: begin
                ram_we           = 1'b1;
                n_level          = level_now;
                n_total          = total_now;
                n_win_vld[r_pos] = 1'b1;
                n_pos            = (r_pos == PW'(WINDOW_LEN - 1)) ? '0 : r_pos + PW'(1);
                n_rem            = mean_dvd[DVD_W-1:QW];
                n_dvd_lo         = mean_dvd[QW-1:0];
                n_dvs            = DIV_W'(WINDOW_LEN);
                n_quo            = '0;
                n_cnt            = CW'(QW - 1);
                n_state          = albd_pkg::S_DIVM;
            end
            albd_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_level   = r_level;
                    n_o_beat    = beat_now;
                    n_o_smooth  = r_filt;
                    n_o_peak    = r_peak;
                    n_o_mean    = r_quo;
                    if (beat_now) begin
                        n_last = r_time;
                    end
                    n_state = albd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = albd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= albd_pkg::S_IDLE;
            r_noise_floor <= albd_pkg::NOISE_FLOOR_RST;
            r_smooth      <= albd_pkg::SMOOTH_RST;
            r_min_gap     <= albd_pkg::MIN_GAP_RST;
            r_min_level   <= albd_pkg::MIN_LEVEL_RST;
            r_filt        <= '0;
            r_peak        <= '0;
            r_pos         <= '0;
            r_total       <= '0;
            r_last        <= '0;
            r_win_vld     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_filt      <= n_filt;
            r_peak      <= n_peak;
            r_pos       <= n_pos;
            r_total     <= n_total;
            r_last      <= n_last;
            r_win_vld   <= n_win_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    albd_pkg::REG_NOISE_FLOOR:    r_noise_floor <= i_cfg.data[SB-1:0];
                    albd_pkg::REG_SMOOTH_FACTOR:  r_smooth <= i_cfg.data[albd_pkg::SMOOTH_W-1:0];
                    albd_pkg::REG_MIN_GAP_MS:     r_min_gap <= i_cfg.data[albd_pkg::GAP_W-1:0];
                    albd_pkg::REG_MIN_BEAT_LEVEL: r_min_level <= i_cfg.data[LW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sample <= i_in.sample;
            r_time   <= i_in.time_ms;
        end
        r_acc      <= n_acc;
        r_rem      <= n_rem;
        r_dvd_lo   <= n_dvd_lo;
        r_dvs      <= n_dvs;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_level    <= n_level;
        r_o_level  <= n_o_level;
        r_o_beat   <= n_o_beat;
        r_o_smooth <= n_o_smooth;
        r_o_peak   <= n_o_peak;
        r_o_mean   <= n_o_mean;
    end

    `ALBD_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_fire, !i_in.ready)
    `ALBD_ASSERT_IMP(a_level_range, i_clk, i_rst_n, o_out.valid, o_out.level <= albd_pkg::LEVEL_MAX)
    `ALBD_ASSERT_IMP(a_beat_above_min, i_clk, i_rst_n, o_out.valid && o_out.beat, o_out.level > r_min_level)
    `ALBD_ASSERT_IMP(a_total_range, i_clk, i_rst_n, 1'b1, r_total <= TOT_MAX)

endmodule

FILE: tb/audio_level_beat_detector_core_tb.sv
module audio_level_beat_detector_core_tb;

    localparam int SB             = albd_pkg::SAMPLE_BITS;
    localparam int LW             = albd_pkg::LEVEL_W;
    localparam int TW             = albd_pkg::TIME_W;
    localparam int IW             = albd_pkg::CFG_IDX_W;
    localparam int DW             = albd_pkg::CFG_DATA_W;
    localparam int SW             = albd_pkg::SMOOTH_W;
    localparam int GW             = albd_pkg::GAP_W;
    localparam int WIN_LEN        = albd_pkg::WINDOW_LEN_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_WORDS    = 315;

    localparam int unsigned FULL      = 32'(albd_pkg::FULL_SCALE);
    localparam int unsigned LVL_MAX   = 32'(albd_pkg::LEVEL_MAX);
    localparam int unsigned DECAY_NUM = 32'(albd_pkg::PEAK_DECAY_NUM);
    localparam int unsigned DECAY_SH  = albd_pkg::PEAK_DECAY_SHIFT;

    localparam logic [IW-1:0] REG_UNMAPPED_LOW  = IW'(4);
    localparam logic [IW-1:0] REG_UNMAPPED_HIGH = '1;

    typedef struct {
        logic [LW-1:0] level;
        logic          beat;
        logic [SB-1:0] smoothed;
        logic [SB-1:0] peak;
        logic [LW-1:0] mean;
    } t_level_result;

    class beat_scoreboard;
        t_level_result     expected_q[$];
        int unsigned       noise_floor, smooth_factor, min_gap, min_level;
        int unsigned       filtered, peak_hold, window_total, window_pos;
        int unsigned       window_levels[WIN_LEN];
        logic [TW-1:0]     last_beat;
        int unsigned       mismatches, checked, beats_flagged;

        function new();
            noise_floor   = 32'(albd_pkg::NOISE_FLOOR_RST);
            smooth_factor = 32'(albd_pkg::SMOOTH_RST);
            min_gap       = 32'(albd_pkg::MIN_GAP_RST);
            min_level     = 32'(albd_pkg::MIN_LEVEL_RST);
            filtered      = 0;
            peak_hold     = 0;
            window_total  = 0;
            window_pos    = 0;
            foreach (window_levels[i]) window_levels[i] = 0;
            last_beat     = '0;
            mismatches    = 0;
            checked       = 0;
            beats_flagged = 0;
        endfunction

        function void write_reg(logic [IW-1:0] idx, logic [DW-1:0] data);
            case (idx)
                albd_pkg::REG_NOISE_FLOOR:    noise_floor   = 32'(data[SB-1:0]);
                albd_pkg::REG_SMOOTH_FACTOR:  smooth_factor = 32'(data[SW-1:0]);
                albd_pkg::REG_MIN_GAP_MS:     min_gap       = 32'(data[GW-1:0]);
                albd_pkg::REG_MIN_BEAT_LEVEL: min_level     = 32'(data[LW-1:0]);
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_word(logic [SB-1:0] smp, logic [TW-1:0] stamp);
            t_level_result     want;
            int unsigned       lvl, mean, thr;
            logic [TW-1:0]     since;
            filtered = (smooth_factor * filtered + (256 - smooth_factor) * 32'(smp)) >> 8;
            if (filtered > FULL) filtered = FULL;
            lvl = 0;
            if (noise_floor < FULL && filtered > noise_floor) begin
                lvl = (filtered - noise_floor) * 100 / (FULL - noise_floor);
                if (lvl > LVL_MAX) lvl = LVL_MAX;
            end
            if (filtered > peak_hold) begin
                peak_hold = filtered;
            end else begin
                peak_hold = (peak_hold * DECAY_NUM) >> DECAY_SH;
            end
            window_total = window_total - window_levels[window_pos] + lvl;
            window_levels[window_pos] = lvl;
            window_pos = (window_pos + 1) % WIN_LEN;
            mean = window_total / WIN_LEN;
            thr = mean + (mean >> 1);
            since = stamp - last_beat;
            want.beat = 1'b0;
            if (lvl > thr && lvl > min_level && since > TW'(min_gap)) begin
                want.beat = 1'b1;
                last_beat = stamp;
                beats_flagged++;
            end
            want.level    = LW'(lvl);
            want.smoothed = SB'(filtered);
            want.peak     = SB'(peak_hold);
            want.mean     = LW'(mean);
            expected_q.push_back(want);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            end
        endfunction

        function void check_word(t_level_result got);
            t_level_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word, level %0d beat %0d",
                         $time, got.level, got.beat);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare("level", 32'(want.level), 32'(got.level));
            compare("beat", 32'(want.beat), 32'(got.beat));
            compare("smoothed_sample", 32'(want.smoothed), 32'(got.smoothed));
            compare("peak", 32'(want.peak), 32'(got.peak));
            compare("window_mean", 32'(want.mean), 32'(got.mean));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    albd_in_if  in_ch();
    albd_out_if out_ch();
    albd_cfg_if cfg_ch();

    audio_level_beat_detector_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    beat_scoreboard    board;
    bit                no_stall;
    int unsigned       stall_left;
    int unsigned       idle_cycles;
    int unsigned       words_sent;
    int unsigned       settings_used;
    logic [TW-1:0]     cur_time;
    t_level_result     seen;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned idle_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                seen.level    = out_ch.level;
                seen.beat     = out_ch.beat;
                seen.smoothed = out_ch.smoothed_sample;
                seen.peak     = out_ch.peak;
                seen.mean     = out_ch.window_mean;
                board.check_word(seen);
            end
            if (no_stall) begin
                stall_left = 0;
                out_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < 12) begin
                stall_left = idle_len() - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_word(input logic [SB-1:0] smp, input logic [TW-1:0] stamp);
        int unsigned gap;
        gap = 0;
        if (!no_stall && $urandom_range(0, 99) >= 70) gap = idle_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.sample  <= smp;
        in_ch.time_ms <= stamp;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_word(smp, stamp);
        words_sent++;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.write_reg(idx, data);
    endtask

    task automatic configure(input int unsigned floor_v, input int unsigned smooth_v,
                             input int unsigned gap_v, input int unsigned level_v,
                             input bit dirty);
        logic [DW-1:0] junk;
        settle();
        junk = dirty ? DW'($urandom) : '0;
        write_reg(albd_pkg::REG_NOISE_FLOOR, {junk[DW-1:SB], SB'(floor_v)});
        write_reg(albd_pkg::REG_SMOOTH_FACTOR, {junk[DW-1:SW], SW'(smooth_v)});
        write_reg(albd_pkg::REG_MIN_GAP_MS, GW'(gap_v));
        write_reg(albd_pkg::REG_MIN_BEAT_LEVEL, {junk[DW-1:LW], LW'(level_v)});
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input int unsigned count);
        int unsigned       burst_left;
        int unsigned       roll;
        logic [SB-1:0]     smp;
        logic [TW-1:0]     stamp;
        burst_left = 0;
        for (int n = 0; n < count; n++) begin
            no_stall = (n < 40);
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                smp   = SB'($urandom);
                stamp = $urandom;
            end else begin
                if (burst_left > 0) begin
                    smp = SB'($urandom_range(2000, 4095));
                    burst_left--;
                end else begin
                    smp = SB'($urandom_range(0, 600));
                    if ($urandom_range(0, 11) == 0) burst_left = $urandom_range(1, 4);
                end
                if ($urandom_range(0, 49) == 0) begin
                    cur_time = 32'hFFFF_FF00 + $urandom_range(0, 255);
                end else begin
                    cur_time = cur_time + $urandom_range(1, 120);
                end
                stamp = cur_time;
            end
            send_word(smp, stamp);
        end
        no_stall = 1'b0;
    endtask

    initial begin
        board         = new();
        no_stall      = 1'b0;
        words_sent    = 0;
        settings_used = 1;
        cur_time      = 32'd5000;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.sample  <= '0;
        in_ch.time_ms <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= '0;
        cfg_ch.data   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(12'd0, 32'd0);
        send_word(12'd4095, 32'd50);
        send_word(12'd4095, 32'd101);
        send_word(12'd4095, 32'd102);
        send_word(12'hAAA, 32'hFFFF_FFFF);
        send_word(12'h555, 32'h5555_5555);
        send_word(12'd4095, 32'hAAAA_AAAA);
        send_word(12'd0, 32'hFFFF_FFF0);

        // With no smoothing the filter output equals the sample, so repeats hit peak ties.
        configure(200, 0, 100, 20, 1'b0);
        send_word(12'd0, 32'd1000);
        send_word(12'd3000, 32'd1200);
        send_word(12'd3000, 32'd1250);
        send_word(12'd3000, 32'd1400);
        send_word(12'd0, 32'd1500);
        send_word(12'd4095, 32'hFFFF_FFC0);
        send_word(12'd0, 32'hFFFF_FFD0);
        send_word(12'd4095, 32'h0000_0010);
        send_word(12'd4095, 32'h0000_0030);

        configure(4095, 255, 0, 127, 1'b0);
        send_word(12'd4095, 32'd2000);
        send_word(12'd4095, 32'd3000);
        send_word(12'd0, 32'd4000);

        configure(0, 128, 65535, 100, 1'b0);
        send_word(12'd4095, 32'd70000);
        send_word(12'd0, 32'd80000);
        send_word(12'd4095, 32'd200000);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: configure(200, 205, 100, 20, 1'b0);
                1: configure(0, 0, 0, 0, 1'b0);
                2: configure(4094, 255, 65535, 100, 1'b0);
                3: configure(4095, 128, 50, 127, 1'b1);
                4: configure($urandom_range(0, 2000), $urandom_range(0, 255),
                             $urandom_range(0, 400), $urandom_range(0, 60), 1'b1);
                default: configure(1000, 1, 10, 5, 1'b1);
            endcase
            if (p == 4) begin
                write_reg(REG_UNMAPPED_LOW, DW'($urandom));
                write_reg(REG_UNMAPPED_HIGH, DW'($urandom));
                cfg_ch.valid <= 1'b0;
            end
            run_phase(PHASE_WORDS);
        end

        settle();
        $display("Sent %0d sample words under %0d register settings; %0d results checked.",
                 words_sent, settings_used, board.checked);
        $display("Beats predicted: %0d; mismatches: %0d.", board.beats_flagged,
                 board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/albd_pkg.sv
rtl/albd_if.sv
rtl/albd_ram.sv
rtl/audio_level_beat_detector_core.sv
tb/audio_level_beat_detector_core_tb.sv
